>>> rtl/cfb_pkg.sv
// Package for the command frame builder: payload structs, command codes,
// frame constants and the CRC-16/GSM byte update.
// No dependencies.
package cfb_pkg;

    typedef enum logic [2:0] {
        FUNC_DELETE      = 3'd0,
        FUNC_DOWNLOAD    = 3'd1,
        FUNC_UPLOAD      = 3'd2,
        FUNC_INIT_UPLOAD = 3'd3,
        FUNC_PLAY        = 3'd4,
        FUNC_PLAY_STREAM = 3'd5
    } func_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] slot;
        logic [15:0] chunk;
    } cmd_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
    } frame_t;

    localparam logic [7:0] SYNC0 = 8'h3F;
    localparam logic [7:0] SYNC1 = 8'hAA;
    localparam logic [7:0] SYNC2 = 8'h55;

    localparam logic [7:0] LEN_DELETE = 8'h03;
    localparam logic [7:0] LEN_INIT   = 8'h01;
    localparam logic [7:0] LEN_FULL   = 8'h07;

    localparam logic [7:0] SUB_DELETE   = 8'h88;
    localparam logic [7:0] SUB_DOWNLOAD = 8'h82;
    localparam logic [7:0] SUB_UPLOAD   = 8'h84;
    localparam logic [7:0] SUB_INIT     = 8'h86;
    localparam logic [7:0] SUB_PLAY     = 8'h8A;
    localparam logic [7:0] PLAY_MODE    = 8'h01;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // first frame byte held in the descriptor body, and how many follow
    localparam int BODY_BASE  = 3;
    localparam int BODY_BYTES = 9;

    // frame index of the CRC high byte
    localparam logic [3:0] CRC_AT_INIT   = 4'd6;
    localparam logic [3:0] CRC_AT_DELETE = 4'd8;
    localparam logic [3:0] CRC_AT_FULL   = 4'd12;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [3:0]                  crc_at;
        logic [BODY_BYTES-1:0][7:0] body;
    } desc_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/cfb_front.sv
// Front end: accepts command items, drops unknown commands and turns the rest
// into frame descriptors for the queue. Depends on cfb_pkg.
module cfb_front
    import cfb_pkg::*;
(
    input  cmd_t  cmd,
    input  logic  cmd_valid,
    output logic  cmd_ready,
    input  logic  q_full,
    output logic  push,
    output desc_t push_desc
);

    logic known;

    always_comb
    begin
        known     = 1'b1;
        push_desc = '0;
        case (func_t'(cmd.func))
            FUNC_DELETE:
            begin
                push_desc.crc_at  = CRC_AT_DELETE;
                push_desc.body[0] = LEN_DELETE;
                push_desc.body[2] = SUB_DELETE;
                push_desc.body[3] = cmd.slot[7:0];
                push_desc.body[4] = cmd.slot[15:8];
            end
            FUNC_DOWNLOAD, FUNC_UPLOAD:
            begin
                push_desc.crc_at  = CRC_AT_FULL;
                push_desc.body[0] = LEN_FULL;
                push_desc.body[2] = (cmd.func == FUNC_DOWNLOAD) ? SUB_DOWNLOAD : SUB_UPLOAD;
                push_desc.body[3] = cmd.slot[7:0];
                push_desc.body[5] = cmd.chunk[7:0];
                push_desc.body[6] = cmd.chunk[15:8];
            end
            FUNC_INIT_UPLOAD:
            begin
                push_desc.crc_at  = CRC_AT_INIT;
                push_desc.body[0] = LEN_INIT;
                push_desc.body[2] = SUB_INIT;
            end
            FUNC_PLAY:
            begin
                push_desc.crc_at  = CRC_AT_FULL;
                push_desc.body[0] = LEN_FULL;
                push_desc.body[2] = SUB_PLAY;
                push_desc.body[3] = PLAY_MODE;
                push_desc.body[5] = cmd.slot[7:0];
                push_desc.body[6] = cmd.slot[15:8];
            end
            FUNC_PLAY_STREAM:
            begin
                push_desc.crc_at  = CRC_AT_FULL;
                push_desc.body[0] = LEN_FULL;
                push_desc.body[2] = SUB_PLAY;
                push_desc.body[3] = PLAY_MODE;
                push_desc.body[5] = cmd.slot[7:0];
                push_desc.body[6] = cmd.chunk[7:0];
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // unknown commands are taken and dropped
    assign cmd_ready = !q_full;
    assign push      = cmd_valid && !q_full && known;

endmodule

>>> rtl/cfb_queue.sv
// Descriptor queue between the front end and the frame serializer.
// Depends on cfb_pkg.
module cfb_queue
    import cfb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> rtl/cfb_back.sv
// Back end: walks the head descriptor one frame byte per cycle when not stalled,
// runs the CRC-16/GSM over the covered bytes and drives the registered output.
// Depends on cfb_pkg.
module cfb_back
    import cfb_pkg::*;
#(
    parameter int FRAME_BYTES = 64
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   head_valid,
    input  desc_t  head,
    output logic   pop,
    output logic   frame_valid,
    input  logic   frame_ready,
    output frame_t frame
);

    localparam int CNT_W = $clog2(FRAME_BYTES);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic             out_valid_reg, out_valid_next;
    frame_t           out_reg, out_next;

    logic             advance;
    logic             last_idx;
    logic [CNT_W-1:0] crc_hi_at;
    logic [CNT_W-1:0] body_off;
    logic [3:0]       body_sel;
    logic             in_body;
    logic [7:0]       cur_byte;

    assign advance   = head_valid && (!out_valid_reg || frame_ready);
    assign last_idx  = (idx_reg == CNT_W'(FRAME_BYTES - 1));
    assign crc_hi_at = CNT_W'(head.crc_at);
    assign body_off  = idx_reg - CNT_W'(BODY_BASE);
    assign body_sel  = body_off[3:0];
    assign in_body   = (idx_reg >= CNT_W'(BODY_BASE)) && (idx_reg < crc_hi_at);
    assign pop       = advance && last_idx;

    always_comb
    begin
        if (idx_reg == CNT_W'(0))
        begin
            cur_byte = SYNC0;
        end
        else if (idx_reg == CNT_W'(1))
        begin
            cur_byte = SYNC1;
        end
        else if (idx_reg == CNT_W'(2))
        begin
            cur_byte = SYNC2;
        end
        else if (in_body)
        begin
            cur_byte = head.body[body_sel];
        end
        else if (idx_reg == crc_hi_at)
        begin
            cur_byte = ~crc_reg[15:8];
        end
        else if (idx_reg == crc_hi_at + 1'b1)
        begin
            cur_byte = ~crc_reg[7:0];
        end
        else
        begin
            cur_byte = 8'h00;
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !frame_ready;
        if (advance)
        begin
            idx_next            = last_idx ? '0 : idx_reg + 1'b1;
            out_next.frame_byte = cur_byte;
            out_next.last       = last_idx;
            out_valid_next      = 1'b1;
            if (idx_reg == CNT_W'(0))
            begin
                crc_next = '0;
            end
            else if (in_body)
            begin
                crc_next = crc16_byte(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign frame_valid = out_valid_reg;
    assign frame       = out_reg;

endmodule

>>> rtl/command_frame_builder_crc16_unit.sv
// Top level of the command frame builder: front end, descriptor queue and
// frame serializer. Depends on cfb_pkg, cfb_front, cfb_queue, cfb_back.
//
//   channel | dir | handshake                | payload
//   --------+-----+--------------------------+----------------------------
//   cmd     | in  | cmd_valid / cmd_ready     | cmd_t   (func, slot, chunk)
//   frame   | out | frame_valid / frame_ready | frame_t (frame_byte, last)
//
// Each known command yields FRAME_BYTES output items, one per cycle while
// frame_ready does not stall; the serializer's byte counter sets the rate.
// A taken command is written into a queue slot; its first byte then goes to the output register.
// Unknown commands are taken and produce nothing.
// The queue holds two commands, the one being sent among them; cmd_ready drops
// only when it is full. frame_ready low stalls the serializer only.
// Reset empties the queue and the output register; no clearing pass.
module command_frame_builder_crc16_unit
    import cfb_pkg::*;
#(
    parameter int FRAME_BYTES = 64
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cmd_valid,
    output logic   cmd_ready,
    input  cmd_t   cmd,
    output logic   frame_valid,
    input  logic   frame_ready,
    output frame_t frame
);

    logic  q_full;
    logic  push;
    desc_t push_desc;
    logic  pop;
    logic  head_valid;
    desc_t head;

    cfb_front u_front (
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    cfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cfb_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

endmodule

>>> rtl/cfb_checker.sv
// Port-level checks for the command frame builder, bound to the top level.
// Depends on cfb_pkg and command_frame_builder_crc16_unit.
module cfb_checker
    import cfb_pkg::*;
#(
    parameter int FRAME_BYTES = 64
)
(
    input logic   clk,
    input logic   rst_n,
    input logic   cmd_valid,
    input logic   cmd_ready,
    input cmd_t   cmd,
    input logic   frame_valid,
    input logic   frame_ready,
    input frame_t frame
);

    localparam int CNT_W = $clog2(FRAME_BYTES);

    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             pos_last;

    assign pos_last = (pos_reg == CNT_W'(FRAME_BYTES - 1));

    always_comb
    begin
        pos_next = pos_reg;
        if (frame_valid && frame_ready)
        begin
            pos_next = pos_last ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame))
        else $error("output item changed while stalled");

    a_sync_first: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && (pos_reg == '0) |-> frame.frame_byte == SYNC0)
        else $error("frame does not open with sync byte");

    a_last_place: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (frame.last == pos_last))
        else $error("last flag out of place");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && (pos_reg == CNT_W'(4)) |-> frame.frame_byte == 8'h00)
        else $error("frame byte 4 not zero");

    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.func > FUNC_PLAY_STREAM) |=> !$fell(cmd_ready))
        else $error("dropped command filled the queue");

endmodule

bind command_frame_builder_crc16_unit cfb_checker #(
    .FRAME_BYTES (FRAME_BYTES)
) u_cfb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
);
